// File: design/cqs_pkg.sv
// Shared types, codes and defaults for the circular queue with search.
package cqs_pkg;

  localparam int DEPTH_DEFAULT = 8;
  localparam int WORD_W        = 32;

  // Operation selector codes carried in the func field.
  localparam logic [1:0] FUNC_ENQ  = 2'd0;
  localparam logic [1:0] FUNC_DEQ  = 2'd1;
  localparam logic [1:0] FUNC_SRCH = 2'd2;

  // Result status codes.
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_EMPTY    = 2'd2;
  localparam logic [1:0] ST_NOTFOUND = 2'd3;

  typedef struct packed {
    logic [1:0]               func;
    logic signed [WORD_W-1:0] enqueue_value;
    logic signed [WORD_W-1:0] search_key;
  } in_item_t;

  typedef struct packed {
    logic [1:0]               status;
    logic signed [WORD_W-1:0] removed_value;
    logic [2:0]               found_slot;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       latch_in;
    logic       do_enq;
    logic       do_deq;
    logic       scan_start;
    logic       scan_next;
    logic       res_init;
    logic [1:0] res_status;
    logic       res_removed;
    logic       res_match;
    logic       load_out;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [1:0] op;
    logic       empty;
    logic       full;
    logic       match;
    logic       at_tail;
  } stat_t;

endpackage

// File: design/cqs_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module cqs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: design/cqs_ctrl.sv
// Controller state machine sequencing enqueue, dequeue and search items.
module cqs_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  logic          out_stall,
  input  cqs_pkg::stat_t stat,
  output cqs_pkg::cmd_t  cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_DEQ  = 3'd2;
  localparam logic [2:0] S_SCAN = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch_in = 1'b1;
          state_nxt    = S_EXEC;
        end
      end
      S_EXEC: begin
        unique case (stat.op)
          cqs_pkg::FUNC_ENQ: begin
            cmd.res_init = 1'b1;
            if (stat.full) begin
              cmd.res_status = cqs_pkg::ST_FULL;
            end else begin
              cmd.res_status = cqs_pkg::ST_OK;
              cmd.do_enq     = 1'b1;
            end
            state_nxt = S_DONE;
          end
          cqs_pkg::FUNC_DEQ: begin
            cmd.res_init = 1'b1;
            if (stat.empty) begin
              cmd.res_status = cqs_pkg::ST_EMPTY;
              state_nxt      = S_DONE;
            end else begin
              cmd.res_status = cqs_pkg::ST_OK;
              cmd.do_deq     = 1'b1;
              state_nxt      = S_DEQ;
            end
          end
          cqs_pkg::FUNC_SRCH: begin
            cmd.res_init = 1'b1;
            if (stat.empty) begin
              cmd.res_status = cqs_pkg::ST_EMPTY;
              state_nxt      = S_DONE;
            end else begin
              cmd.res_status = cqs_pkg::ST_NOTFOUND;
              cmd.scan_start = 1'b1;
              state_nxt      = S_SCAN;
            end
          end
          default: begin
            // Unused selector: dropped without a result.
            state_nxt = S_IDLE;
          end
        endcase
      end
      S_DEQ: begin
        cmd.res_removed = 1'b1;
        state_nxt       = S_DONE;
      end
      S_SCAN: begin
        if (stat.match) begin
          cmd.res_match = 1'b1;
          state_nxt     = S_DONE;
        end else if (stat.at_tail) begin
          state_nxt = S_DONE;
        end else begin
          cmd.scan_next = 1'b1;
        end
      end
      S_DONE: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_valid_nxt = cmd.load_out || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule

// File: design/cqs_dp.sv
// Datapath: ring pointers, slot storage, search comparator and result registers.
module cqs_dp #(
  parameter int DEPTH = cqs_pkg::DEPTH_DEFAULT
) (
  input  logic               clk,
  input  logic               rst_n,
  input  cqs_pkg::in_item_t  in_data,
  output cqs_pkg::out_item_t out_data,
  input  cqs_pkg::cmd_t      cmd,
  output cqs_pkg::stat_t     stat
);

  localparam int AW = $clog2(DEPTH);

  logic [AW-1:0] head_r, head_nxt;
  logic [AW-1:0] tail_r, tail_nxt;
  logic          empty_r, empty_nxt;
  logic [AW-1:0] scan_r;

  logic [1:0]                        op_r;
  logic signed [cqs_pkg::WORD_W-1:0] val_r;
  logic signed [cqs_pkg::WORD_W-1:0] key_r;

  logic [1:0]                        res_status_r;
  logic signed [cqs_pkg::WORD_W-1:0] res_removed_r;
  logic [2:0]                        res_found_r;
  cqs_pkg::out_item_t                out_r;

  logic [AW-1:0]                ram_waddr;
  logic [AW-1:0]                ram_raddr;
  logic [cqs_pkg::WORD_W-1:0]   ram_rdata;

  function automatic logic [AW-1:0] next_slot(input logic [AW-1:0] s);
    return (s == AW'(DEPTH - 1)) ? '0 : s + AW'(1);
  endfunction

  // An enqueue into an empty queue restarts at slot zero.
  assign ram_waddr = empty_r ? '0 : next_slot(tail_r);
  assign ram_raddr = cmd.scan_next ? next_slot(scan_r) : head_r;

  cqs_ram #(
    .WIDTH(cqs_pkg::WORD_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (cmd.do_enq),
    .waddr(ram_waddr),
    .wdata(val_r),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_comb begin
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    empty_nxt = empty_r;
    if (cmd.do_enq) begin
      if (empty_r) begin
        head_nxt  = '0;
        tail_nxt  = '0;
        empty_nxt = 1'b0;
      end else begin
        tail_nxt = next_slot(tail_r);
      end
    end else if (cmd.do_deq) begin
      if (head_r == tail_r) begin
        head_nxt  = '0;
        tail_nxt  = '0;
        empty_nxt = 1'b1;
      end else begin
        head_nxt = next_slot(head_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      empty_r <= 1'b1;
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      empty_r <= empty_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      op_r  <= in_data.func;
      val_r <= in_data.enqueue_value;
      key_r <= in_data.search_key;
    end
    if (cmd.scan_start) begin
      scan_r <= head_r;
    end else if (cmd.scan_next) begin
      scan_r <= next_slot(scan_r);
    end
    if (cmd.res_init) begin
      res_status_r  <= cmd.res_status;
      res_removed_r <= '0;
      res_found_r   <= '0;
    end
    if (cmd.res_removed) begin
      res_removed_r <= ram_rdata;
    end
    if (cmd.res_match) begin
      res_status_r <= cqs_pkg::ST_OK;
      res_found_r  <= 3'(scan_r);
    end
    if (cmd.load_out) begin
      out_r.status        <= res_status_r;
      out_r.removed_value <= res_removed_r;
      out_r.found_slot    <= res_found_r;
    end
  end

  assign stat.op      = op_r;
  assign stat.empty   = empty_r;
  assign stat.full    = !empty_r && (next_slot(tail_r) == head_r);
  assign stat.match   = (ram_rdata == key_r);
  assign stat.at_tail = (scan_r == tail_r);

  assign out_data = out_r;

endmodule

// File: design/circular_queue_with_search.sv
// An enqueue, a failed dequeue or a search of an empty queue goes from the execute state
// to the done state; a dequeue passes the dequeue state and a search the scan state between.
// The block takes a new item only once the last result has been loaded out, and a search
// walks the queue through the single RAM read port one slot per cycle.
// An unused selector is dropped without a result and frees the input.
// Reset (synchronous, active low) empties the queue; slot contents are not cleared.
module circular_queue_with_search #(
  parameter int DEPTH = cqs_pkg::DEPTH_DEFAULT
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  cqs_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output cqs_pkg::out_item_t out_data
);

  // The controller only sequences; every piece of queue state lives in the datapath.
  // The two halves talk through one command struct and one status struct.
  cqs_pkg::cmd_t  cmd;
  cqs_pkg::stat_t stat;

  // The controller takes one item at a time. The finished result sits in the output
  // register, so a new item is accepted while the previous result still waits to be
  // taken; only the final hand-over waits for the output register to be free.
  cqs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // The datapath holds head, tail and the empty flag, the slot RAM and the key
  // comparator. A search issues one read per cycle from the head and stops at the
  // first match or once the tail slot has been compared.
  cqs_dp #(
    .DEPTH(DEPTH)
  ) u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_data (in_data),
    .out_data(out_data),
    .cmd     (cmd),
    .stat    (stat)
  );

endmodule
